// ===== rtl/aph_pkg.sv =====
// Package with constants, types and helper functions for the allpass phaser.
package aph_pkg;

	localparam int MaxStagesDefault = 16;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 24;

	localparam logic [CfgIdxW-1:0] REG_PHASE_STEP = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_SWEEP_MIN = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_SWEEP_MAX = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_FB_GAIN = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_DEPTH_GAIN = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_STAGE_CNT = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_X2,
		ST_X3,
		ST_X5,
		ST_POLY,
		ST_SINE,
		ST_D,
		ST_DGO,
		ST_DIV,
		ST_FB,
		ST_RD,
		ST_MUL1,
		ST_MUL2,
		ST_TANH,
		ST_OUT,
		ST_HOLD
	} aph_state_t;

	function automatic logic signed [15:0] tanh_rom(input logic [4:0] i);
		case (i)
			5'd0: tanh_rom = 16'sd0;
			5'd1: tanh_rom = 16'sd2045;
			5'd2: tanh_rom = 16'sd4075;
			5'd3: tanh_rom = 16'sd6073;
			5'd4: tanh_rom = 16'sd8026;
			5'd5: tanh_rom = 16'sd9919;
			5'd6: tanh_rom = 16'sd11743;
			5'd7: tanh_rom = 16'sd13486;
			5'd8: tanh_rom = 16'sd15143;
			5'd9: tanh_rom = 16'sd16706;
			5'd10: tanh_rom = 16'sd18173;
			5'd11: tanh_rom = 16'sd19542;
			5'd12: tanh_rom = 16'sd20813;
			5'd13: tanh_rom = 16'sd21986;
			5'd14: tanh_rom = 16'sd23066;
			5'd15: tanh_rom = 16'sd24054;
			default: tanh_rom = 16'sd24956;
		endcase
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
		if (v < -48'sd8388608) begin
			sat24 = -24'sd8388608;
		end else if (v > 48'sd8388607) begin
			sat24 = 24'sd8388607;
		end else begin
			sat24 = v[23:0];
		end
	endfunction

endpackage

// ===== rtl/aph_div.sv =====
// Restoring divider, one quotient bit per cycle, for the allpass coefficient.
module aph_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [32:0] num,
	input  logic [17:0] den,
	output logic busy,
	output logic [32:0] quo
);
	import aph_pkg::*;

	logic [5:0] cnt_q;
	logic [17:0] rem_q;
	logic [32:0] quo_q;
	logic [18:0] trial;

	assign trial = {rem_q, quo_q[32]} - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd33;
		end else if (cnt_q != 6'd0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (cnt_q != 6'd0) begin
			if (!trial[18]) begin
				rem_q <= trial[17:0];
				quo_q <= {quo_q[31:0], 1'b1};
			end else begin
				rem_q <= {rem_q[16:0], quo_q[32]};
				quo_q <= {quo_q[31:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != 6'd0);
	assign quo = quo_q;

	property p_busy_after_start;
		@(posedge clk) disable iff (!arst_n) start |=> busy;
	endproperty
	a_busy_after_start: assert property (p_busy_after_start) else $error("divider idle after start");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && $past(busy)) |-> ({1'b0, rem_q} < {1'b0, den} || $past(start)))
		else $error("divider remainder out of range");
	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && !start) |=> (cnt_q == $past(cnt_q) - 6'd1)) else $error("divider count");
endmodule

// ===== rtl/allpass_phaser_core.sv =====
// Top level of the LFO-swept allpass phaser with its stage memory and sequencer.
// Usage: drive sample_in with sample_in_valid; the block raises sample_in_ready when
// it can take a word. Each accepted word yields exactly one sample_out word on the
// valid/ready output channel. Configuration is written through cfg_we, cfg_idx and
// cfg_data while no word is in flight.
// Processing: the accepted word passes the sine and sweep arithmetic, the restoring
// divider for the coefficient, feedback, then a memory read and two multiplies per
// allpass stage on the single-port stage memory, over n stages with n being
// stage_count capped at MAX_STAGES, and last tanh and the output.
// Flow: words are processed one at a time; the output register lets the next word be
// accepted while the previous result still waits.
// Reset: clears the LFO phase and the feedback sample; per-entry valid bits make the
// stage memory read as zero until written, so the block is ready right after reset.
// Stall: if sample_out_ready stays low, the result is held and the next word
// finishes processing, then waits until the output register frees.
module allpass_phaser_core #(
	parameter int MAX_STAGES = aph_pkg::MaxStagesDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [aph_pkg::CfgIdxW-1:0] cfg_idx,
	input  logic [aph_pkg::CfgDataW-1:0] cfg_data,
	input  logic signed [15:0] sample_in,
	input  logic sample_in_valid,
	output logic sample_in_ready,
	output logic signed [15:0] sample_out,
	output logic sample_out_valid,
	input  logic sample_out_ready
);
	import aph_pkg::*;

	localparam int AW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
	localparam int CW = $clog2(MAX_STAGES + 1) > 5 ? $clog2(MAX_STAGES + 1) : 5;

	logic [23:0] phase_step_q;
	logic [15:0] sweep_min_q, sweep_max_q, fb_gain_q, depth_gain_q;
	logic [4:0] stage_cnt_q;

	logic [23:0] phase_q;
	logic signed [15:0] fb_q;

	logic signed [23:0] mem [MAX_STAGES];
	logic [MAX_STAGES-1:0] mvalid_q;
	logic signed [23:0] rd_q;

	aph_state_t st_q, st_d;
	logic signed [15:0] x_q;
	logic [16:0] xs_q, x2_q, x3_q, x5_q;
	logic [16:0] sv_q;
	logic signed [47:0] acc_q;
	logic [16:0] d_q;
	logic [16:0] a_q;
	logic signed [23:0] y_q, ys_q;
	logic [AW-1:0] idx_q;
	logic [CW-1:0] n_q, i_q;
	logic signed [15:0] out_q;
	logic oval_q;

	logic div_start;
	logic div_busy;
	logic [32:0] quo;
	logic [32:0] num;
	logic [17:0] den;

	// Configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= 24'd190;
			sweep_min_q <= 16'd1308;
			sweep_max_q <= 16'd4755;
			fb_gain_q <= 16'd22938;
			depth_gain_q <= 16'd32768;
			stage_cnt_q <= 5'd12;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_PHASE_STEP: phase_step_q <= cfg_data;
				REG_SWEEP_MIN: sweep_min_q <= cfg_data[15:0];
				REG_SWEEP_MAX: sweep_max_q <= cfg_data[15:0];
				REG_FB_GAIN: fb_gain_q <= cfg_data[15:0];
				REG_DEPTH_GAIN: depth_gain_q <= cfg_data[15:0];
				REG_STAGE_CNT: stage_cnt_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign num = {(17'd65536 - d_q), 16'd0} + {16'd0, den[17:1]};
	assign den = {1'b0, d_q} + 18'd65536;
	assign div_start = (st_q == ST_DGO);

	aph_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(num), .den(den),
		.busy(div_busy), .quo(quo)
	);

	// Combinational helpers.
	logic signed [47:0] rnd16, rnd15;
	logic signed [23:0] ycl;
	logic [15:0] mag;
	logic signed [16:0] tdiff;
	logic signed [31:0] tprod;
	logic signed [16:0] tval;
	logic signed [23:0] mem_rd;
	logic signed [47:0] out_sum;

	assign mem_rd = mvalid_q[idx_q] ? rd_q : 24'sd0;
	assign rnd16 = (acc_q + 48'sd32768) >>> 16;
	assign rnd15 = (acc_q + 48'sd16384) >>> 15;
	assign ycl = (y_q < -24'sd32768) ? -24'sd32768 : (y_q > 24'sd32768 ? 24'sd32768 : y_q);
	assign mag = ycl[23] ? 16'(-ycl) : 16'(ycl);
	assign tdiff = 17'(tanh_rom({1'b0, mag[14:11]} + 5'd1)) - 17'(tanh_rom({1'b0, mag[14:11]}));
	assign tprod = 32'(tdiff) * $signed({21'd0, mag[10:0]});
	assign tval = mag[15] ? 17'(tanh_rom(5'd16))
		: 17'(tanh_rom({1'b0, mag[14:11]})) + 17'((tprod + 32'sd1024) >>> 11);
	assign out_sum = 48'(x_q) + rnd15;

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (sample_in_valid) st_d = ST_X2;
			ST_X2: st_d = ST_X3;
			ST_X3: st_d = ST_X5;
			ST_X5: st_d = ST_POLY;
			ST_POLY: st_d = ST_SINE;
			ST_SINE: st_d = ST_D;
			ST_D: st_d = ST_DGO;
			ST_DGO: st_d = ST_DIV;
			ST_DIV: if (!div_busy) st_d = ST_FB;
			ST_FB: st_d = (n_q == '0) ? ST_TANH : ST_RD;
			ST_RD: st_d = ST_MUL1;
			ST_MUL1: st_d = ST_MUL2;
			ST_MUL2: st_d = (i_q + 1'b1 == n_q) ? ST_TANH : ST_RD;
			ST_TANH: st_d = ST_OUT;
			ST_OUT: st_d = oval_q ? ST_HOLD : ST_IDLE;
			ST_HOLD: if (!oval_q) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	assign sample_in_ready = (st_q == ST_IDLE);
	assign sample_out = out_q;
	assign sample_out_valid = oval_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			phase_q <= '0;
			fb_q <= '0;
			mvalid_q <= '0;
			oval_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_D) phase_q <= phase_q + phase_step_q;
			if (st_q == ST_TANH) fb_q <= ycl[23] ? -tval[15:0] : tval[15:0];
			if (st_q == ST_MUL2) mvalid_q[idx_q] <= 1'b1;
			if (st_q == ST_OUT && !oval_q) begin
				oval_q <= 1'b1;
			end else if (st_q == ST_HOLD && !oval_q) begin
				oval_q <= 1'b1;
			end else if (oval_q && sample_out_ready) begin
				oval_q <= 1'b0;
			end
		end
	end

	// Stage memory: registered read, write back after the second multiply.
	always_ff @(posedge clk) begin
		rd_q <= mem[idx_q];
		if (st_q == ST_MUL2) mem[idx_q] <= sat24(rnd16 + 48'(y_q));
	end

	logic [16:0] xm;
	logic signed [47:0] poly;
	assign xm = phase_q[22] ? (17'd65536 - {1'b0, phase_q[21:6]}) : {1'b0, phase_q[21:6]};
	assign poly = 48'sd102944 * $signed({31'd0, xs_q}) - 48'sd42177 * $signed({31'd0, x3_q})
		+ 48'sd4769 * $signed({31'd0, x5_q});

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				x_q <= sample_in;
				xs_q <= xm;
				n_q <= (CW'(stage_cnt_q) > CW'(MAX_STAGES)) ? CW'(MAX_STAGES) : CW'(stage_cnt_q);
			end
			ST_X2: x2_q <= 17'((34'(xs_q) * 34'(xs_q)) >> 16);
			ST_X3: x3_q <= 17'((34'(x2_q) * 34'(xs_q)) >> 16);
			ST_X5: x5_q <= 17'((34'(x3_q) * 34'(x2_q)) >> 16);
			ST_POLY: acc_q <= poly;
			ST_SINE: begin
				if (acc_q < 0) begin
					sv_q <= 17'd0;
				end else if ((acc_q >>> 16) > 48'sd65536) begin
					sv_q <= 17'd32768;
				end else begin
					sv_q <= 17'(((acc_q >>> 16) + 48'sd1) >>> 1);
				end
			end
			ST_D: ;
			ST_DIV: begin
				acc_q <= 48'(fb_q) * $signed({32'd0, fb_gain_q});
				a_q <= quo[16:0];
				i_q <= '0;
				idx_q <= '0;
			end
			ST_FB: y_q <= sat24(48'(x_q) + rnd15);
			ST_RD: acc_q <= 48'($signed({1'b0, a_q})) * 48'(y_q);
			ST_MUL1: begin
				ys_q <= sat24(48'(mem_rd) - rnd16);
				acc_q <= 48'($signed({1'b0, a_q})) * 48'(sat24(48'(mem_rd) - rnd16));
			end
			ST_MUL2: begin
				y_q <= ys_q;
				i_q <= i_q + 1'b1;
				idx_q <= AW'(i_q + 1'b1);
			end
			ST_TANH: acc_q <= 48'(ycl) * $signed({32'd0, depth_gain_q});
			ST_OUT, ST_HOLD: begin
				if (!oval_q) begin
					if (out_sum > 48'sd32767) out_q <= 16'sd32767;
					else if (out_sum < -48'sd32768) out_q <= -16'sd32768;
					else out_q <= 16'(out_sum);
				end
			end
			default: ;
		endcase
		if (st_q == ST_D) begin
			d_q <= 17'((32'(sweep_min_q) * (32'd65536 - 32'(17'd32768 + (phase_q[23] ?
				-sv_q : sv_q))) + 32'(sweep_max_q) * 32'(17'd32768 + (phase_q[23] ?
				-sv_q : sv_q))) >> 16);
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sample_in_ready |-> (st_q == ST_IDLE)) else $error("ready outside idle");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(oval_q && !sample_out_ready) |=> (oval_q && $stable(out_q))) else $error("output lost");
	a_stage_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RD) |-> (i_q < n_q)) else $error("stage index past count");
endmodule

// ===== sim/allpass_phaser_core_tb.sv =====
// Self-checking testbench for the allpass phaser core: directed table, random words and a bit-exact predictor.
`timescale 1ns / 1ps

module allpass_phaser_core_tb;
	import aph_pkg::*;

	localparam int NumStages = 16;
	localparam int CycleLimit = 2000000;
	localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

	typedef struct {
		logic signed [15:0] smp;
		bit has_exp;
		logic signed [15:0] exp;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_idx;
	logic [CfgDataW-1:0] cfg_data;
	logic signed [15:0] sample_in;
	logic sample_in_valid;
	logic sample_in_ready;
	logic signed [15:0] sample_out;
	logic sample_out_valid;
	logic sample_out_ready;

	int src_idle_pct;
	int snk_idle_pct;
	int mismatches;
	int outputs_seen;
	int cycles;
	int words_sent;

	// Predictor state and configuration.
	logic [23:0] mdl_phase_step;
	logic [15:0] mdl_sweep_min;
	logic [15:0] mdl_sweep_max;
	logic [15:0] mdl_fb_gain;
	logic [15:0] mdl_depth_gain;
	logic [4:0] mdl_stage_cnt;
	logic [23:0] mdl_lfo_phase;
	longint mdl_fb_sample;
	longint mdl_stage_mem [NumStages];

	logic signed [15:0] out_expected [$];

	allpass_phaser_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.sample_in(sample_in),
		.sample_in_valid(sample_in_valid),
		.sample_in_ready(sample_in_ready),
		.sample_out(sample_out),
		.sample_out_valid(sample_out_valid),
		.sample_out_ready(sample_out_ready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint rnd_shift(longint v, int sh);
		return (v + (longint'(1) << (sh - 1))) >>> sh;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic longint sine_q15(logic [23:0] ph);
		longint x;
		longint x2;
		longint x3;
		longint x5;
		longint s;
		x = longint'(ph[21:6]);
		if (ph[22]) x = 65536 - x;
		x2 = (x * x) >>> 16;
		x3 = (x2 * x) >>> 16;
		x5 = (x3 * x2) >>> 16;
		s = 102944 * x - 42177 * x3 + 4769 * x5;
		if (s < 0) s = 0;
		s = s >>> 16;
		if (s > 65536) s = 65536;
		s = (s + 1) >>> 1;
		return ph[23] ? -s : s;
	endfunction

	function automatic longint tanh_lookup(int k);
		int tbl [17] = '{0, 2045, 4075, 6073, 8026, 9919, 11743, 13486, 15143,
			16706, 18173, 19542, 20813, 21986, 23066, 24054, 24956};
		return tbl[k];
	endfunction

	function automatic longint soft_clip(longint y);
		longint m;
		longint k;
		longint t;
		m = (y < 0) ? -y : y;
		k = m >>> 11;
		if (k >= 16) begin
			t = tanh_lookup(16);
		end else begin
			t = tanh_lookup(int'(k)) + (((tanh_lookup(int'(k) + 1) - tanh_lookup(int'(k)))
				* (m & 2047) + 1024) >>> 11);
		end
		return (y < 0) ? -t : t;
	endfunction

	function automatic logic signed [15:0] phaser_sample(logic signed [15:0] smp);
		longint xin;
		longint w;
		longint d;
		longint den;
		longint a;
		longint y;
		longint ys;
		int n;
		xin = longint'(smp);
		w = 32768 + sine_q15(mdl_lfo_phase);
		d = (longint'(mdl_sweep_min) * (65536 - w) + longint'(mdl_sweep_max) * w) >>> 16;
		mdl_lfo_phase = mdl_lfo_phase + mdl_phase_step;
		den = 65536 + d;
		a = (((65536 - d) << 16) + (den >>> 1)) / den;
		y = clamp(xin + rnd_shift(mdl_fb_sample * longint'(mdl_fb_gain), 15),
			-8388608, 8388607);
		n = (mdl_stage_cnt > NumStages) ? NumStages : int'(mdl_stage_cnt);
		for (int i = 0; i < n; i++) begin
			ys = clamp(mdl_stage_mem[i] - rnd_shift(a * y, 16), -8388608, 8388607);
			mdl_stage_mem[i] = clamp(rnd_shift(a * ys, 16) + y, -8388608, 8388607);
			y = ys;
		end
		y = clamp(y, -32768, 32768);
		mdl_fb_sample = soft_clip(y);
		return 16'(clamp(xin + rnd_shift(y * longint'(mdl_depth_gain), 15), -32768, 32767));
	endfunction

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [23:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_PHASE_STEP: mdl_phase_step = val;
			REG_SWEEP_MIN: mdl_sweep_min = val[15:0];
			REG_SWEEP_MAX: mdl_sweep_max = val[15:0];
			REG_FB_GAIN: mdl_fb_gain = val[15:0];
			REG_DEPTH_GAIN: mdl_depth_gain = val[15:0];
			REG_STAGE_CNT: mdl_stage_cnt = val[4:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		sample_in_valid <= 1'b0;
		while (out_expected.size() > 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic send_word(logic signed [15:0] smp, bit has_exp, logic signed [15:0] exp);
		logic signed [15:0] pred;
		while ($urandom_range(99) < src_idle_pct) begin
			sample_in_valid <= 1'b0;
			@(posedge clk);
		end
		sample_in <= smp;
		sample_in_valid <= 1'b1;
		@(posedge clk);
		while (!sample_in_ready) @(posedge clk);
		pred = phaser_sample(smp);
		out_expected.push_back(has_exp ? exp : pred);
		words_sent++;
	endtask

	task automatic random_config();
		write_reg(REG_PHASE_STEP, ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(4000)));
		write_reg(REG_SWEEP_MIN, 16'($urandom));
		write_reg(REG_SWEEP_MAX, 16'($urandom));
		write_reg(REG_FB_GAIN, ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(32768)));
		write_reg(REG_DEPTH_GAIN, ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(32768)));
		write_reg(REG_STAGE_CNT, 5'($urandom));
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			cycles <= cycles + 1;
			sample_out_ready <= ($urandom_range(99) >= snk_idle_pct);
			if (sample_out_valid && sample_out_ready) begin
				outputs_seen <= outputs_seen + 1;
				if (out_expected.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10) $display("Unexpected word %0d", sample_out);
				end else begin
					if (sample_out !== out_expected[0]) begin
						mismatches = mismatches + 1;
						if (mismatches <= 10)
							$display("Word %0d: expected %0d, got %0d", outputs_seen,
								out_expected[0], sample_out);
					end
					void'(out_expected.pop_front());
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CycleLimit) begin
			$display("Timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		dir_row_t dir_rows [$];
		logic signed [15:0] smp;
		int phase;
		int r;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		sample_in = '0;
		sample_in_valid = 1'b0;
		sample_out_ready = 1'b0;
		mismatches = 0;
		outputs_seen = 0;
		cycles = 0;
		words_sent = 0;
		src_idle_pct = 11;
		snk_idle_pct = 69;
		mdl_phase_step = 24'd190;
		mdl_sweep_min = 16'd1308;
		mdl_sweep_max = 16'd4755;
		mdl_fb_gain = 16'd22938;
		mdl_depth_gain = 16'd32768;
		mdl_stage_cnt = 5'd12;
		mdl_lfo_phase = '0;
		mdl_fb_sample = 0;
		foreach (mdl_stage_mem[i]) mdl_stage_mem[i] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings first.
		dir_rows.push_back('{16'sd0, 1'b0, 16'sd0});
		dir_rows.push_back('{16'sh7fff, 1'b0, 16'sd0});
		dir_rows.push_back('{-16'sd32768, 1'b0, 16'sd0});
		dir_rows.push_back('{16'sd1, 1'b0, 16'sd0});
		dir_rows.push_back('{-16'sd1, 1'b0, 16'sd0});
		dir_rows.push_back('{16'sh5555, 1'b0, 16'sd0});
		dir_rows.push_back('{16'shaaaa, 1'b0, 16'sd0});
		foreach (dir_rows[i]) send_word(dir_rows[i].smp, dir_rows[i].has_exp, dir_rows[i].exp);
		drain();

		// With zero stages and zero feedback the output is dry plus wet, saturated.
		write_reg(REG_STAGE_CNT, 5'd0);
		write_reg(REG_FB_GAIN, 16'd0);
		write_reg(REG_DEPTH_GAIN, 16'd32768);
		send_word(16'sh7fff, 1'b1, 16'sh7fff);
		send_word(-16'sd32768, 1'b1, -16'sd32768);
		send_word(16'sd1000, 1'b1, 16'sd2000);
		drain();

		// Gains above unity, inverted sweep, too many stages, odd register index.
		write_reg(REG_FB_GAIN, 16'hffff);
		write_reg(REG_DEPTH_GAIN, 16'hffff);
		write_reg(REG_SWEEP_MIN, 16'hffff);
		write_reg(REG_SWEEP_MAX, 16'd0);
		write_reg(REG_STAGE_CNT, 5'd31);
		write_reg(REG_PHASE_STEP, 24'hffffff);
		write_reg(RegUnused, 24'h123456);
		send_word(16'sh7fff, 1'b0, 16'sd0);
		send_word(-16'sd32768, 1'b0, 16'sd0);
		send_word(16'sh4000, 1'b0, 16'sd0);
		send_word(16'sd0, 1'b0, 16'sd0);
		drain();
		write_reg(REG_STAGE_CNT, 5'd16);
		write_reg(REG_SWEEP_MIN, 16'd0);
		write_reg(REG_SWEEP_MAX, 16'hffff);
		send_word(16'sh7fff, 1'b0, 16'sd0);
		send_word(-16'sd32768, 1'b0, 16'sd0);
		send_word(16'sd12345, 1'b0, 16'sd0);
		drain();
		write_reg(REG_STAGE_CNT, 5'd1);
		send_word(16'sd77, 1'b0, 16'sd0);
		drain();

		for (phase = 0; phase < 3; phase++) begin
			src_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 69 : 0;
			snk_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 11 : 0;
			for (int blk = 0; blk < 4; blk++) begin
				random_config();
				for (int k = 0; k < 58; k++) begin
					r = $urandom_range(9);
					if (r == 0) smp = ($urandom_range(1)) ? 16'sh7fff : -16'sd32768;
					else if (r < 4) smp = 16'($urandom);
					else smp = 16'($signed($urandom_range(8000)) - 4000);
					send_word(smp, 1'b0, 16'sd0);
				end
				drain();
			end
		end

		$display("Sent %0d words over directed cases and 12 random register settings,",
			words_sent);
		$display("checked %0d output words under three flow-control mixes.", outputs_seen);
		if (mismatches == 0 && out_expected.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
